### sv/rdfesc_pkg.sv
// Shared types, constants and helper functions for the RDF text escape encoder.
// Used by every module of the block; depends on nothing else.
package rdfesc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCII_ONLY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BS_FF = 2'd1;

  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;
  localparam logic [1:0] KIND_URI   = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_VBAR   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;

  localparam logic [7:0] REPL_0 = 8'hEF;
  localparam logic [7:0] REPL_1 = 8'hBF;
  localparam logic [7:0] REPL_2 = 8'hBD;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_RAW,
    ACT_ESC,
    ACT_HEX4,
    ACT_HEX8,
    ACT_UTF8
  } action_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic        rep;
    action_t     act;
    logic [2:0]  ulen;
    logic [31:0] value;
    logic [3:0]  total;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'd0, d};
    end else begin
      r = 8'h37 + {4'd0, d};
    end
    return r;
  endfunction

endpackage

### sv/rdf_text_escape_encoder_core.sv
// Top level of the RDF text escape encoder: configuration registers, front
// end, job queue and back end. Depends on rdfesc_pkg and the rdfesc modules.
//
// Usage: input bytes of UTF-8 text enter through a queue-style port; a
// transfer happens at a clock edge with push high and full low. Each byte
// carries its context (short string, long string or URI) and an end-of-text
// mark. Escaped output bytes leave through a second queue-style port: the
// oldest byte is on result while empty is low, and a transfer happens at an
// edge with pop high and empty low. The last byte caused by one input byte
// carries last_of_run; an input byte may cause no output at all.
// Configuration writes use cfg_valid/cfg_ready (always ready), an index and
// one data bit; the user must make them while the block is idle, unchecked.
// Path: an input byte's job is registered in the job queue, then the back
// end's byte sequencer writes its output bytes into the result buffer.
// Throughput: one output byte per cycle while the result buffer has room,
// so plain ASCII sustains one input byte per cycle; an escape of n bytes
// takes n back-end bytes, and full rises once four jobs wait in the queue.
// Reset clears the decoder state and both queues and loads the register
// defaults (ascii_only 0, escape_bs_ff 1). A stalled receiver fills the
// result buffer and then the job queue, after which full holds off input.
module rdf_text_escape_encoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  rdfesc_pkg::item_t                   item,
  output logic                                empty,
  input  logic                                pop,
  output rdfesc_pkg::result_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdfesc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                                cfg_data
);
  import rdfesc_pkg::*;

  logic ascii_only;
  logic escape_bs_ff;
  logic accept;
  logic job_push;
  job_t job_in;
  logic job_valid;
  job_t job_head;
  logic job_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_only   <= 1'b0;
      escape_bs_ff <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ASCII_ONLY:   ascii_only   <= cfg_data;
        CFG_ESCAPE_BS_FF: escape_bs_ff <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rdfesc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .ascii_only   (ascii_only),
    .escape_bs_ff (escape_bs_ff),
    .job_push     (job_push),
    .job          (job_in)
  );

  rdfesc_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .full    (full),
    .pop     (job_pop),
    .valid   (job_valid),
    .job_out (job_head)
  );

  rdfesc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### sv/rdfesc_front.sv
// Front end: accepts input bytes, tracks UTF-8 decoding state and classifies
// each byte into at most one output job. Depends on rdfesc_pkg.
module rdfesc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  rdfesc_pkg::item_t  item,
  input  logic               ascii_only,
  input  logic               escape_bs_ff,
  output logic               job_push,
  output rdfesc_pkg::job_t   job
);
  import rdfesc_pkg::*;

  logic [31:0] pend, pend_next;
  logic [2:0]  need, need_next;
  logic [2:0]  held, held_next;
  logic        skip, skip_next;

  logic [7:0]  b;
  logic        eot;
  logic [31:0] cat;
  logic [2:0]  held_inc;
  logic [2:0]  lead_len;
  logic        emit_char;
  logic        do_asc;
  logic        fresh;
  logic        rep;

  action_t     asc_act;
  logic [7:0]  asc_val;
  action_t     chr_act;
  logic [31:0] chr_val;
  logic [20:0] cp;
  action_t     act;
  logic [31:0] val;
  logic [3:0]  alen;
  logic        printable;
  logic        uri_special;

  assign b   = item.in_byte;
  assign eot = item.end_of_text;
  assign cat = {pend[23:0], b};
  assign held_inc = held + 3'd1;

  always_comb begin
    if (b[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  always_comb begin
    pend_next = pend;
    need_next = need;
    held_next = held;
    skip_next = skip;
    rep       = 1'b0;
    emit_char = 1'b0;
    do_asc    = 1'b0;
    fresh     = 1'b1;
    if (need != 3'd0) begin
      fresh = 1'b0;
      if (b[7:6] == 2'b10) begin
        pend_next = cat;
        held_next = held_inc;
        if (held_inc >= need) begin
          emit_char = 1'b1;
          pend_next = '0;
          need_next = '0;
          held_next = '0;
        end else if (eot) begin
          rep = 1'b1;
        end
      end else begin
        rep = 1'b1;
        pend_next = '0;
        need_next = '0;
        held_next = '0;
        if (b[7]) begin
          skip_next = !eot;
        end else begin
          do_asc = 1'b1;
        end
      end
    end else if (skip) begin
      if (b[7]) begin
        fresh = 1'b0;
      end else begin
        skip_next = 1'b0;
      end
    end
    if (fresh) begin
      if (!b[7]) begin
        do_asc = 1'b1;
      end else if (lead_len == 3'd0) begin
        rep = 1'b1;
        skip_next = !eot;
      end else if (eot) begin
        rep = 1'b1;
      end else begin
        pend_next = {24'd0, b};
        need_next = lead_len;
        held_next = 3'd1;
      end
    end
    if (eot) begin
      pend_next = '0;
      need_next = '0;
      held_next = '0;
      skip_next = 1'b0;
    end
  end

  always_comb begin
    printable = (b >= CH_SPACE) && (b <= CH_TILDE);
    uri_special = !printable || b == CH_SPACE || b == CH_QUOTE || b == CH_LT ||
                  b == CH_GT || b == CH_BSLASH || b == CH_CARET || b == CH_BTICK ||
                  b == CH_LBRACE || b == CH_VBAR || b == CH_RBRACE;
    asc_act = ACT_HEX4;
    asc_val = b;
    if (item.kind != KIND_SHORT && item.kind != KIND_LONG) begin
      asc_act = uri_special ? ACT_HEX4 : ACT_RAW;
    end else if (printable && b != CH_BSLASH && b != CH_QUOTE) begin
      asc_act = ACT_RAW;
    end else if (item.kind == KIND_LONG) begin
      case (b)
        CH_BSLASH: begin
          asc_act = ACT_ESC;
        end
        CH_BS: begin
          asc_act = ACT_ESC;
          asc_val = CH_LOW_B;
        end
        CH_LF, CH_CR, CH_TAB, CH_FF: begin
          asc_act = ACT_RAW;
        end
        CH_QUOTE: begin
          asc_act = eot ? ACT_ESC : ACT_RAW;
        end
        default: begin
          asc_act = ACT_HEX4;
        end
      endcase
    end else begin
      case (b)
        CH_BSLASH, CH_QUOTE: begin
          asc_act = ACT_ESC;
        end
        CH_LF: begin
          asc_act = ACT_ESC;
          asc_val = CH_LOW_N;
        end
        CH_CR: begin
          asc_act = ACT_ESC;
          asc_val = CH_LOW_R;
        end
        CH_TAB: begin
          asc_act = ACT_ESC;
          asc_val = CH_LOW_T;
        end
        CH_BS: begin
          asc_act = escape_bs_ff ? ACT_ESC : ACT_HEX4;
          asc_val = escape_bs_ff ? CH_LOW_B : b;
        end
        CH_FF: begin
          asc_act = escape_bs_ff ? ACT_ESC : ACT_HEX4;
          asc_val = escape_bs_ff ? CH_LOW_F : b;
        end
        default: begin
          asc_act = ACT_HEX4;
        end
      endcase
    end
  end

  always_comb begin
    case (held_inc)
      3'd2:    cp = {10'd0, cat[12:8], cat[5:0]};
      3'd3:    cp = {5'd0, cat[19:16], cat[13:8], cat[5:0]};
      default: cp = {cat[26:24], cat[21:16], cat[13:8], cat[5:0]};
    endcase
    if (!ascii_only) begin
      chr_act = ACT_UTF8;
      chr_val = cat;
    end else begin
      chr_act = (cp[20:16] == 5'd0) ? ACT_HEX4 : ACT_HEX8;
      chr_val = {11'd0, cp};
    end
  end

  always_comb begin
    if (emit_char) begin
      act = chr_act;
      val = chr_val;
    end else if (do_asc) begin
      act = asc_act;
      val = {24'd0, asc_val};
    end else begin
      act = ACT_NONE;
      val = '0;
    end
    case (act)
      ACT_RAW:  alen = 4'd1;
      ACT_ESC:  alen = 4'd2;
      ACT_HEX4: alen = 4'd6;
      ACT_HEX8: alen = 4'd10;
      ACT_UTF8: alen = {1'b0, held_inc};
      default:  alen = 4'd0;
    endcase
  end

  assign job.rep   = rep;
  assign job.act   = act;
  assign job.ulen  = held_inc;
  assign job.value = val;
  assign job.total = (rep ? 4'd3 : 4'd0) + alen;
  assign job_push  = accept && (rep || act != ACT_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      need <= '0;
      held <= '0;
      skip <= 1'b0;
    end else if (accept) begin
      pend <= pend_next;
      need <= need_next;
      held <= held_next;
      skip <= skip_next;
    end
  end

endmodule

### sv/rdfesc_job_queue.sv
// Four-entry job queue between the front end and the back end.
// Depends on rdfesc_pkg for the job type.
module rdfesc_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rdfesc_pkg::job_t  job_in,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output rdfesc_pkg::job_t  job_out
);
  import rdfesc_pkg::*;

  job_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full    = count == 3'd4;
  assign valid   = count != 3'd0;
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

### sv/rdfesc_back.sv
// Back end: expands each job into output bytes in a two-entry result buffer,
// one per cycle while the buffer has room. Depends on rdfesc_pkg.
module rdfesc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  rdfesc_pkg::job_t    job,
  output logic                job_pop,
  output rdfesc_pkg::result_t result,
  output logic                empty,
  input  logic                pop
);
  import rdfesc_pkg::*;

  logic [3:0] idx;
  logic [3:0] j;
  logic [2:0] sh;
  logic [3:0] nib;
  logic [1:0] bsel;
  logic [7:0] byte_out;
  logic       last;
  logic       emit;

  result_t    obuf [2];
  logic       owr;
  logic       ord;
  logic [1:0] ocount;
  logic       opop;

  assign j    = job.rep ? idx - 4'd3 : idx;
  assign sh   = (job.act == ACT_HEX8) ? 3'(4'd9 - j) : 3'(4'd5 - j);
  assign nib  = job.value[{sh, 2'b00} +: 4];
  assign bsel = 2'(job.ulen - 3'd1 - j[2:0]);

  always_comb begin
    if (job.rep && idx < 4'd3) begin
      case (idx[1:0])
        2'd0:    byte_out = REPL_0;
        2'd1:    byte_out = REPL_1;
        default: byte_out = REPL_2;
      endcase
    end else begin
      case (job.act)
        ACT_RAW: begin
          byte_out = job.value[7:0];
        end
        ACT_ESC: begin
          byte_out = (j == 4'd0) ? CH_BSLASH : job.value[7:0];
        end
        ACT_HEX4, ACT_HEX8: begin
          if (j == 4'd0) begin
            byte_out = CH_BSLASH;
          end else if (j == 4'd1) begin
            byte_out = (job.act == ACT_HEX8) ? CH_UP_U : CH_LOW_U;
          end else begin
            byte_out = hex_digit(nib);
          end
        end
        ACT_UTF8: begin
          byte_out = job.value[{bsel, 3'b000} +: 8];
        end
        default: begin
          byte_out = 8'd0;
        end
      endcase
    end
  end

  assign last    = idx == job.total - 4'd1;
  assign emit    = job_valid && ocount != 2'd2;
  assign job_pop = emit && last;
  assign opop    = pop && ocount != 2'd0;
  assign empty   = ocount == 2'd0;
  assign result  = obuf[ord];

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf[owr] <= '{out_byte: byte_out, last_of_run: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= '0;
    end else begin
      if (emit) begin
        idx <= last ? 4'd0 : idx + 4'd1;
        owr <= !owr;
      end
      if (opop) begin
        ord <= !ord;
      end
      ocount <= ocount + {1'b0, emit} - {1'b0, opop};
    end
  end

endmodule

### sv/rdfesc_checker.sv
// Port-level checks for the RDF text escape encoder, attached by bind.
// Depends on rdfesc_pkg and rdf_text_escape_encoder_core.
module rdfesc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                full,
  input  logic                                empty,
  input  logic                                pop,
  input  rdfesc_pkg::result_t                 result
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // Once a run has started, the next byte of it is ready right after a transfer.
  a_run_continuous: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_of_run) |=> !empty)
    else $error("gap inside an output run");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind rdf_text_escape_encoder_core rdfesc_checker u_rdfesc_checker (.*);
